### src/mlpc_pkg.sv
// ----------------------------------------------------------------------------
// mlpc_pkg
// Shared types and constants of the motorized lift position controller.
// ----------------------------------------------------------------------------
package mlpc_pkg;

   // field widths
   localparam int COUNT_W    = 32;
   localparam int PCT_W      = 15;
   localparam int PULSE_W    = 31;
   localparam int LEVEL_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // divider sizing: 25600 * |count| fits in 47 bits
   localparam int PROD_W    = 47;
   localparam int DIV_STEPS = PROD_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam int REM_W     = PULSE_W + 1;
   localparam int POS_W     = PROD_W + 2;

   // constants
   localparam logic [PCT_W-1:0]   FULL_Q8     = 15'd25600;
   localparam logic [LEVEL_W-1:0] DRIVE_LEVEL = 8'd255;
   localparam logic [PULSE_W-1:0] MAXP_RESET  = 31'd10000;
   localparam logic [PCT_W-1:0]   DB_RESET    = 15'd256;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIBRATION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PULSES  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND    = 2'd3;

   // motion mode
   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_RISING   = 3'd1,
      MODE_LOWERING = 3'd2,
      MODE_TOP      = 3'd3,
      MODE_BOTTOM   = 3'd4
   } mode_type;

   // sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FIX,
      ST_DECIDE
   } seq_state_type;

endpackage

### src/mlpc_req_if.sv
// ----------------------------------------------------------------------------
// mlpc_req_if
// Tick channel: encoder count, setpoint and jog requests.
// ----------------------------------------------------------------------------
interface mlpc_req_if
   import mlpc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] encoder_count;
   logic [PCT_W-1:0]   setpoint;
   logic               jog_up;
   logic               jog_down;

   modport source (output valid, encoder_count, setpoint, jog_up, jog_down, input ready);
   modport sink (input valid, encoder_count, setpoint, jog_up, jog_down, output ready);
endinterface

### src/mlpc_rsp_if.sv
// ----------------------------------------------------------------------------
// mlpc_rsp_if
// Result channel: position, mode, bridge drive, reload request, stop edge.
// ----------------------------------------------------------------------------
interface mlpc_rsp_if
   import mlpc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] position_pct;
   logic [2:0]         mode;
   logic               drive_up;
   logic               drive_down;
   logic [LEVEL_W-1:0] drive_enable;
   logic               reload_encoder;
   logic [PULSE_W-1:0] reload_value;
   logic               stopped;

   modport source (output valid, position_pct, mode, drive_up, drive_down, drive_enable,
                   reload_encoder, reload_value, stopped, input ready);
   modport sink (input valid, position_pct, mode, drive_up, drive_down, drive_enable,
                 reload_encoder, reload_value, stopped, output ready);
endinterface

### src/mlpc_csr_if.sv
// ----------------------------------------------------------------------------
// mlpc_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mlpc_csr_if
   import mlpc_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### src/motorized_lift_position_controller.sv
// ----------------------------------------------------------------------------
// motorized_lift_position_controller
// Encoder based lift position tracking, end detection and bridge drive.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one refresh tick per word (encoder count, setpoint, jogs).
//   rsp_ch returns exactly one word per tick. csr_ch writes the four
//   registers (enabled, calibration_mode, max_pulses, deadband) and is always
//   ready; write it only while no tick is in flight.
//   When the count differs from the previous one, the position is recomputed
//   as 25600 - 25600*count/max_pulses by a restoring divider that retires one
//   quotient bit per cycle. From accept to result a tick passes a product
//   step, the divider steps, a saturate step and a mode update step. A tick
//   with an unchanged count, or while disabled, skips the divider (and the
//   product and saturate steps). req_ch is ready only when the sequencer is
//   idle; one tick is worked on at a time.
//   The result sits in an output register; a stalled receiver holds the next
//   tick in its saturate step (or in its final step when the divider was
//   skipped) until that register is free.
//   Synchronous reset returns registers to their defaults and clears all
//   motion state.
// ----------------------------------------------------------------------------
module motorized_lift_position_controller
   import mlpc_pkg::*;
   (
   input  logic   clock,
   input  logic   reset,
   mlpc_req_if.sink   req_ch,
   mlpc_rsp_if.source rsp_ch,
   mlpc_csr_if.sink   csr_ch
   );

   localparam logic signed [POS_W-1:0] P_MAX = 49'sd2147483647;
   localparam logic signed [POS_W-1:0] P_MIN = -49'sd2147483648;

   // configuration
   logic               enabled_ff;
   logic               calib_ff;
   logic [PULSE_W-1:0] maxp_ff;
   logic [PCT_W-1:0]   deadband_ff;

   // sequencer and captured word
   seq_state_type      state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [PCT_W-1:0]   setpoint_ff, setpoint_in;
   logic               jog_up_ff, jog_up_in;
   logic               jog_down_ff, jog_down_in;
   logic               moving_ff, moving_in;

   // divider
   logic [PROD_W-1:0]  quo_ff, quo_in;
   logic [REM_W-2:0]   rem_ff, rem_in;
   logic [PULSE_W-1:0] dvsr_ff, dvsr_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   // motion state
   logic [COUNT_W-1:0] last_count_ff, last_count_in;
   logic [COUNT_W-1:0] position_ff, position_in;
   mode_type           mode_ff, mode_in;
   logic               was_moving_ff, was_moving_in;
   logic               bridge_up_ff, bridge_up_in;
   logic               bridge_down_ff, bridge_down_in;
   logic [LEVEL_W-1:0] level_ff, level_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               reload_ff, reload_in;
   logic [PULSE_W-1:0] reload_val_ff, reload_val_in;
   logic               stopped_ff, stopped_in;

   logic req_fire;
   logic out_free;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff  <= 1'b0;
         calib_ff    <= 1'b0;
         maxp_ff     <= MAXP_RESET;
         deadband_ff <= DB_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_ENABLED:     enabled_ff  <= csr_ch.data[0];
            CSR_CALIBRATION: calib_ff    <= csr_ch.data[0];
            CSR_MAX_PULSES:  maxp_ff     <= csr_ch.data[PULSE_W-1:0];
            CSR_DEADBAND:    deadband_ff <= csr_ch.data[PCT_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer next state, divider and decision logic
   always_comb begin
      logic [COUNT_W-1:0]        mag;
      logic [REM_W-1:0]          trial;
      logic signed [POS_W-1:0]   q_signed;
      logic signed [POS_W-1:0]   p_full;
      logic                      cnt_gt;
      logic signed [COUNT_W:0]   err;
      logic signed [COUNT_W:0]   db;
      logic                      want_lower;
      logic                      want_raise;
      mode_type                  m;

      state_in       = state_ff;
      count_in       = count_ff;
      setpoint_in    = setpoint_ff;
      jog_up_in      = jog_up_ff;
      jog_down_in    = jog_down_ff;
      moving_in      = moving_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      dvsr_in        = dvsr_ff;
      step_in        = step_ff;
      last_count_in  = last_count_ff;
      position_in    = position_ff;
      mode_in        = mode_ff;
      was_moving_in  = was_moving_ff;
      bridge_up_in   = bridge_up_ff;
      bridge_down_in = bridge_down_ff;
      level_in       = level_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      reload_in      = reload_ff;
      reload_val_in  = reload_val_ff;
      stopped_in     = stopped_ff;

      mag      = count_ff[COUNT_W-1] ? (~count_ff + 1'b1) : count_ff;
      trial    = {rem_ff, quo_ff[PROD_W-1]} - {1'b0, dvsr_ff};
      q_signed = count_ff[COUNT_W-1] ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff});
      p_full   = $signed({{(POS_W-PCT_W){1'b0}}, FULL_Q8}) - q_signed;
      cnt_gt   = $signed(count_ff) > $signed({1'b0, maxp_ff});
      err      = $signed({position_ff[COUNT_W-1], position_ff})
                 - $signed({{(COUNT_W+1-PCT_W){1'b0}}, setpoint_ff});
      db       = $signed({{(COUNT_W+1-PCT_W){1'b0}}, deadband_ff});
      want_lower = 1'b0;
      want_raise = 1'b0;
      m          = mode_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               count_in    = req_ch.encoder_count;
               setpoint_in = req_ch.setpoint;
               jog_up_in   = req_ch.jog_up;
               jog_down_in = req_ch.jog_down;
               moving_in   = enabled_ff && (req_ch.encoder_count != last_count_ff);
               state_in    = (enabled_ff && (req_ch.encoder_count != last_count_ff))
                             ? ST_MUL : ST_DECIDE;
            end
         end
         ST_MUL: begin
            // 25600 * |count| as shifts: 25600 = 2^14 + 2^13 + 2^10
            quo_in   = ({15'd0, mag} << 14) + ({15'd0, mag} << 13) + ({15'd0, mag} << 10);
            rem_in   = '0;
            dvsr_in  = (maxp_ff == '0) ? PULSE_W'(1) : maxp_ff;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // one restoring step per cycle
            if (!trial[REM_W-1]) begin
               rem_in = trial[REM_W-2:0];
               quo_in = {quo_ff[PROD_W-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[REM_W-3:0], quo_ff[PROD_W-1]};
               quo_in = {quo_ff[PROD_W-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            // saturate to the signed 32-bit range, once the held word is gone
            if (out_free) begin
               if (p_full > P_MAX) begin
                  position_in = P_MAX[COUNT_W-1:0];
               end else if (p_full < P_MIN) begin
                  position_in = P_MIN[COUNT_W-1:0];
               end else begin
                  position_in = p_full[COUNT_W-1:0];
               end
               last_count_in = count_ff;
               state_in      = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               reload_in     = 1'b0;
               reload_val_in = '0;
               stopped_in    = 1'b0;
               state_in      = ST_IDLE;
               if (enabled_ff) begin
                  // top end: stall while rising
                  if (m == MODE_TOP || (m == MODE_RISING && !moving_ff)) begin
                     m         = MODE_TOP;
                     reload_in = 1'b1;
                     reload_val_in = '0;
                  end
                  // bottom end: stall while lowering, or overrun in tracking mode
                  if (m == MODE_BOTTOM || (m == MODE_LOWERING && !moving_ff)
                      || (!calib_ff && cnt_gt)) begin
                     m = MODE_BOTTOM;
                     if (!calib_ff || cnt_gt) begin
                        reload_in     = 1'b1;
                        reload_val_in = maxp_ff;
                     end
                  end
                  // drive request
                  if (calib_ff) begin
                     want_lower = jog_down_ff && !jog_up_ff;
                     want_raise = jog_up_ff && !jog_down_ff;
                  end else begin
                     want_lower = err > db;
                     want_raise = !(err > db) && (err < -db);
                  end
                  if (want_lower) begin
                     if (m != MODE_BOTTOM) begin
                        bridge_up_in   = 1'b0;
                        bridge_down_in = 1'b1;
                        level_in       = DRIVE_LEVEL;
                        m              = MODE_LOWERING;
                     end
                  end else if (want_raise) begin
                     if (m != MODE_TOP) begin
                        bridge_up_in   = 1'b1;
                        bridge_down_in = 1'b0;
                        level_in       = DRIVE_LEVEL;
                        m              = MODE_RISING;
                     end
                  end else begin
                     if (m != MODE_TOP && m != MODE_BOTTOM) begin
                        m = MODE_IDLE;
                     end
                     bridge_up_in   = 1'b0;
                     bridge_down_in = 1'b0;
                     level_in       = '0;
                  end
                  mode_in       = m;
                  stopped_in    = !moving_ff && was_moving_ff;
                  was_moving_in = moving_ff;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // motion state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         last_count_ff  <= '0;
         position_ff    <= '0;
         mode_ff        <= MODE_IDLE;
         was_moving_ff  <= 1'b0;
         bridge_up_ff   <= 1'b0;
         bridge_down_ff <= 1'b0;
         level_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         last_count_ff  <= last_count_in;
         position_ff    <= position_in;
         mode_ff        <= mode_in;
         was_moving_ff  <= was_moving_in;
         bridge_up_ff   <= bridge_up_in;
         bridge_down_ff <= bridge_down_in;
         level_ff       <= level_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      setpoint_ff   <= setpoint_in;
      jog_up_ff     <= jog_up_in;
      jog_down_ff   <= jog_down_in;
      moving_ff     <= moving_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      dvsr_ff       <= dvsr_in;
      step_ff       <= step_in;
      reload_ff     <= reload_in;
      reload_val_ff <= reload_val_in;
      stopped_ff    <= stopped_in;
   end

   // result word
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.position_pct   = position_ff;
   assign rsp_ch.mode           = mode_ff;
   assign rsp_ch.drive_up       = bridge_up_ff;
   assign rsp_ch.drive_down     = bridge_down_ff;
   assign rsp_ch.drive_enable   = level_ff;
   assign rsp_ch.reload_encoder = reload_ff;
   assign rsp_ch.reload_value   = reload_val_ff;
   assign rsp_ch.stopped        = stopped_ff;

endmodule

### src/mlpc_checker.sv
// ----------------------------------------------------------------------------
// mlpc_checker
// Port level checks of the lift position controller, bound to the top level.
// ----------------------------------------------------------------------------
module mlpc_checker
   import mlpc_pkg::*;
   (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [COUNT_W-1:0] position_pct,
   input logic               drive_up,
   input logic               drive_down,
   input logic [LEVEL_W-1:0] drive_enable,
   input logic               reload_encoder,
   input logic [PULSE_W-1:0] reload_value
   );

   // a stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(position_pct))
      else $error("stalled result word changed");

   // busy after a tick is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("tick taken while busy");

   // bridge never driven both ways
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(drive_up && drive_down))
      else $error("bridge driven both ways");

   // enable level follows the bridge
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((drive_enable == DRIVE_LEVEL) == (drive_up || drive_down))
                    && (drive_enable == '0 || drive_enable == DRIVE_LEVEL))
      else $error("enable level inconsistent with bridge");

   // no reload value without a reload request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !reload_encoder |-> reload_value == '0)
      else $error("reload value without request");

endmodule

bind motorized_lift_position_controller mlpc_checker u_mlpc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .position_pct   (rsp_ch.position_pct),
   .drive_up       (rsp_ch.drive_up),
   .drive_down     (rsp_ch.drive_down),
   .drive_enable   (rsp_ch.drive_enable),
   .reload_encoder (rsp_ch.reload_encoder),
   .reload_value   (rsp_ch.reload_value)
);

### tb/motorized_lift_position_controller_tb.sv
// ----------------------------------------------------------------------------
// motorized_lift_position_controller_tb
// Self-checking bench for the lift position controller. Tick words go in
// through a queue-fed driver. Each accepted tick runs through a cycle-free
// model of the controller, and each result word is compared field by field
// against the oldest prediction. Directed ticks cover the ends of travel,
// overrun, saturation, calibration jogs and a zero pulse count. Random
// lift runs then follow under several register settings and flow-control
// mixes.
// ----------------------------------------------------------------------------
module motorized_lift_position_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mlpc_pkg::*;

   localparam int     CLK_PERIOD = 12;
   localparam int     TAIL_CYCLES = 60;
   localparam int     RUN_ITEMS = 150;
   localparam int     RUN_SETTINGS = 12;
   localparam longint POS_MAX = 64'sd2147483647;
   localparam longint POS_MIN = -POS_MAX - 1;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [PCT_W-1:0]   setpoint;
      logic               jog_up;
      logic               jog_down;
   } lift_tick_t;

   typedef struct packed {
      logic signed [COUNT_W-1:0] position;
      mode_type                  mode;
      logic                      up;
      logic                      down;
      logic [LEVEL_W-1:0]        level;
      logic                      reload;
      logic [PULSE_W-1:0]        reload_value;
      logic                      stopped;
   } lift_out_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mlpc_req_if req_ch ();
   mlpc_rsp_if rsp_ch ();
   mlpc_csr_if csr_ch ();

   motorized_lift_position_controller uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // register copy, as written through the csr channel
   logic               cfg_enabled = 1'b0;
   logic               cfg_calibration = 1'b0;
   logic [PULSE_W-1:0] cfg_max_pulses = MAXP_RESET;
   logic [PCT_W-1:0]   cfg_deadband = DB_RESET;

   // controller state copy
   logic [COUNT_W-1:0]        lift_last_count = '0;
   logic signed [COUNT_W-1:0] lift_position = '0;
   mode_type                  lift_mode = MODE_IDLE;
   logic                      lift_was_moving = 1'b0;
   logic                      lift_up = 1'b0;
   logic                      lift_down = 1'b0;
   logic [LEVEL_W-1:0]        lift_level = '0;

   // queues and bookkeeping
   lift_tick_t pending_ticks[$];
   lift_out_t  expected_outputs[$];
   lift_tick_t staged_tick;
   logic       tick_taken = 1'b0;
   int         sender_idle_pct = 0;
   int         receiver_stall_pct = 0;
   int         mismatch_count = 0;
   int         ticks_accepted = 0;
   int         results_checked = 0;
   int         reload_results = 0;
   int         stop_results = 0;
   int         settings_count = 0;

   // bridge helpers: raising is blocked at the top end, lowering at the bottom
   function automatic void drive_lower();
      if (lift_mode != MODE_BOTTOM) begin
         lift_up = 1'b0;
         lift_down = 1'b1;
         lift_level = DRIVE_LEVEL;
         lift_mode = MODE_LOWERING;
      end
   endfunction

   function automatic void drive_raise();
      if (lift_mode != MODE_TOP) begin
         lift_up = 1'b1;
         lift_down = 1'b0;
         lift_level = DRIVE_LEVEL;
         lift_mode = MODE_RISING;
      end
   endfunction

   function automatic void drive_hold();
      if (lift_mode != MODE_TOP && lift_mode != MODE_BOTTOM)
         lift_mode = MODE_IDLE;
      lift_up = 1'b0;
      lift_down = 1'b0;
      lift_level = '0;
   endfunction

   // one refresh tick of the controller
   function automatic lift_out_t predict_lift_tick(lift_tick_t t);
      lift_out_t          o;
      longint             cnt;
      longint             maxp;
      longint             pos;
      longint             err;
      longint             db;
      logic               moving;
      logic               reload;
      logic               stop;
      logic [PULSE_W-1:0] reload_val;
      moving = 1'b0;
      reload = 1'b0;
      stop = 1'b0;
      reload_val = '0;
      if (cfg_enabled) begin
         cnt = longint'($signed(t.count));
         maxp = longint'(cfg_max_pulses);
         // new count: recompute position, zero pulse count divides by one
         if (t.count != lift_last_count) begin
            pos = longint'(FULL_Q8)
                  - (longint'(FULL_Q8) * cnt) / ((maxp == 0) ? 64'sd1 : maxp);
            if (pos > POS_MAX)
               pos = POS_MAX;
            else if (pos < POS_MIN)
               pos = POS_MIN;
            moving = 1'b1;
            lift_last_count = t.count;
            lift_position = pos[31:0];
         end
         // top end: stall while rising
         if (lift_mode == MODE_TOP || (lift_mode == MODE_RISING && !moving)) begin
            lift_mode = MODE_TOP;
            reload = 1'b1;
            reload_val = '0;
         end
         // bottom end: stall while lowering, or overrun in tracking mode
         if (lift_mode == MODE_BOTTOM || (lift_mode == MODE_LOWERING && !moving) ||
             (!cfg_calibration && cnt > maxp)) begin
            lift_mode = MODE_BOTTOM;
            if (!cfg_calibration || cnt > maxp) begin
               reload = 1'b1;
               reload_val = cfg_max_pulses;
            end
         end
         // bridge control
         if (cfg_calibration) begin
            if (t.jog_down && !t.jog_up)
               drive_lower();
            else if (t.jog_up && !t.jog_down)
               drive_raise();
            else
               drive_hold();
         end else begin
            err = longint'(lift_position) - longint'(t.setpoint);
            db = longint'(cfg_deadband);
            if (err > db)
               drive_lower();
            else if (err < -db)
               drive_raise();
            else
               drive_hold();
         end
         stop = !moving && lift_was_moving;
         lift_was_moving = moving;
      end
      o.position = lift_position;
      o.mode = lift_mode;
      o.up = lift_up;
      o.down = lift_down;
      o.level = lift_level;
      o.reload = reload;
      o.reload_value = reload_val;
      o.stopped = stop;
      return o;
   endfunction

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         mismatch_count++;
         // keep the log readable when everything goes wrong
         if (mismatch_count <= 100)
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // monitor: registers, accepted ticks and result words at the rising edge
   always @(posedge clock) begin
      tick_taken = req_ch.valid && req_ch.ready && !reset;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_ENABLED:     cfg_enabled = csr_ch.data[0];
               CSR_CALIBRATION: cfg_calibration = csr_ch.data[0];
               CSR_MAX_PULSES:  cfg_max_pulses = csr_ch.data[PULSE_W-1:0];
               CSR_DEADBAND:    cfg_deadband = csr_ch.data[PCT_W-1:0];
               default: ;
            endcase
         end
         if (tick_taken) begin
            expected_outputs.push_back(predict_lift_tick({req_ch.encoder_count,
               req_ch.setpoint, req_ch.jog_up, req_ch.jog_down}));
            ticks_accepted++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_outputs.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: result word with no tick outstanding, expected none, actual %0d",
                        $time, $signed(rsp_ch.position_pct));
            end else begin
               lift_out_t want;
               want = expected_outputs.pop_front();
               check_field("position_pct", longint'(want.position),
                           longint'($signed(rsp_ch.position_pct)));
               check_field("mode", longint'(want.mode), longint'(rsp_ch.mode));
               check_field("drive_up", longint'(want.up), longint'(rsp_ch.drive_up));
               check_field("drive_down", longint'(want.down), longint'(rsp_ch.drive_down));
               check_field("drive_enable", longint'(want.level),
                           longint'(rsp_ch.drive_enable));
               check_field("reload_encoder", longint'(want.reload),
                           longint'(rsp_ch.reload_encoder));
               check_field("reload_value", longint'(want.reload_value),
                           longint'(rsp_ch.reload_value));
               check_field("stopped", longint'(want.stopped), longint'(rsp_ch.stopped));
               results_checked++;
               if (want.reload)
                  reload_results++;
               if (want.stopped)
                  stop_results++;
            end
         end
      end
   end

   // driver: present tick words and toggle the receiver at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (!req_ch.valid || tick_taken) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               staged_tick = pending_ticks.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.encoder_count <= staged_tick.count;
               req_ch.setpoint <= staged_tick.setpoint;
               req_ch.jog_up <= staged_tick.jog_up;
               req_ch.jog_down <= staged_tick.jog_down;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic push_tick(input logic [31:0] cnt, input logic [14:0] sp,
                            input logic up, input logic dn);
      lift_tick_t t;
      t.count = cnt;
      t.setpoint = sp;
      t.jog_up = up;
      t.jog_down = dn;
      pending_ticks.push_back(t);
   endtask

   // wait until every queued tick went out and every result word came back
   task automatic wait_drained();
      do
         @(posedge clock);
      while (pending_ticks.size() != 0 || req_ch.valid || expected_outputs.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do
         @(posedge clock);
      while (!csr_ch.ready);
   endtask

   task automatic set_config(input logic en, input logic cal,
                             input logic [30:0] maxp, input logic [14:0] db);
      wait_drained();
      write_reg(CSR_ENABLED, {31'd0, en});
      write_reg(CSR_CALIBRATION, {31'd0, cal});
      write_reg(CSR_MAX_PULSES, {1'b0, maxp});
      write_reg(CSR_DEADBAND, {17'd0, db});
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
      settings_count++;
   endtask

   task automatic set_flow(input int k);
      case (k % 4)
         0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         1: begin sender_idle_pct = 88; receiver_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  receiver_stall_pct = 88; end
         default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
      endcase
   endtask

   // one lift run: travel in steps, stalls, jitter, reversals and stray counts
   task automatic queue_motion_run(input int n, input longint span);
      longint      c;
      longint      dir;
      int unsigned step_max;
      logic [14:0] sp;
      logic        up;
      logic        dn;
      int          r;
      c = longint'($urandom_range(int'(span), 0));
      dir = $urandom_range(1) ? 1 : -1;
      step_max = int'(span / 16) + 1;
      sp = 15'($urandom_range(25600));
      {up, dn} = 2'($urandom_range(3));
      repeat (n) begin
         r = $urandom_range(99);
         if (r < 55) begin
            c += dir * longint'($urandom_range(step_max, 1));
         end else if (r < 80) begin
            // stall: same count
         end else if (r < 88) begin
            c += $urandom_range(1) ? 1 : -1;
         end else if (r < 94) begin
            dir = -dir;
            if ($urandom_range(3) == 0)
               sp = $urandom_range(1) ? FULL_Q8 : '0;
            else
               sp = 15'($urandom_range(25600));
         end else begin
            case ($urandom_range(5))
               0: c = 0;
               1: c = span;
               2: c = span + 1;
               3: c = POS_MAX;
               4: c = POS_MIN;
               default: c = longint'($signed($urandom()));
            endcase
         end
         if ($urandom_range(99) < 15)
            {up, dn} = 2'($urandom_range(3));
         push_tick(c[31:0], sp, up, dn);
      end
   endtask

   // stimulus
   initial begin : stimulus
      int          k;
      int          sent;
      int          n;
      logic [30:0] maxp;
      logic [14:0] db;
      req_ch.valid = 1'b0;
      req_ch.encoder_count = '0;
      req_ch.setpoint = '0;
      req_ch.jog_up = 1'b0;
      req_ch.jog_down = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_flow(0);

      // disabled: ticks leave the state alone
      set_config(1'b0, 1'b0, 31'd10000, 15'd256);
      push_tick(32'd777, 15'd0, 1'b1, 1'b0);
      push_tick(32'd0, 15'd25600, 1'b0, 1'b1);
      push_tick(-32'sd5, 15'd12800, 1'b1, 1'b1);

      // tracking: ends of travel, overrun, saturation, deadband hold
      set_config(1'b1, 1'b0, 31'd10000, 15'd256);
      push_tick(32'd0, 15'd25600, 1'b0, 1'b0);
      push_tick(32'd0, 15'd25600, 1'b0, 1'b0);
      push_tick(32'd5000, 15'd0, 1'b0, 1'b0);
      push_tick(32'd8000, 15'd0, 1'b0, 1'b0);
      push_tick(32'd8000, 15'd0, 1'b0, 1'b0);
      push_tick(32'd10001, 15'd0, 1'b0, 1'b0);
      push_tick(32'd9990, 15'd25600, 1'b0, 1'b0);
      push_tick(32'h7FFF_FFFF, 15'd0, 1'b1, 1'b0);
      push_tick(32'h8000_0000, 15'd25600, 1'b0, 1'b1);
      push_tick(32'hFFFF_FFFF, 15'd25600, 1'b0, 1'b0);
      push_tick(32'hFFFF_FFFF, 15'd25600, 1'b1, 1'b1);

      // calibration: jog each way, both, neither, stalls at both ends
      set_config(1'b1, 1'b1, 31'd10000, 15'd0);
      push_tick(32'd5000, 15'd0, 1'b0, 1'b1);
      push_tick(32'd5000, 15'd0, 1'b0, 1'b1);
      push_tick(32'd4000, 15'd0, 1'b1, 1'b0);
      push_tick(32'd4000, 15'd0, 1'b1, 1'b0);
      push_tick(32'd12000, 15'd0, 1'b1, 1'b1);
      push_tick(32'd12000, 15'd0, 1'b0, 1'b0);
      push_tick(32'd13000, 15'd0, 1'b0, 1'b1);
      push_tick(32'd13000, 15'd0, 1'b0, 1'b1);

      // zero pulse count divides by one
      set_config(1'b1, 1'b0, 31'd0, 15'd25600);
      push_tick(32'd1, 15'd0, 1'b0, 1'b0);
      push_tick(-32'sd3, 15'd12800, 1'b0, 1'b0);
      push_tick(32'h7FFF_FFFF, 15'd25600, 1'b0, 1'b0);

      // random lift runs over a spread of settings and flow mixes
      for (k = 0; k < RUN_SETTINGS; k++) begin
         case (k % 6)
            0: maxp = 31'd10000;
            1: maxp = 31'd1;
            2: maxp = 31'h7FFF_FFFF;
            3: maxp = 31'($urandom_range(5000, 2));
            4: maxp = 31'($urandom_range(32'h7FFF_FFFF, 1));
            default: maxp = 31'($urandom_range(100000, 100));
         endcase
         case (k % 5)
            0: db = 15'd0;
            1: db = 15'd25600;
            2: db = 15'd256;
            3: db = 15'($urandom_range(25600));
            default: db = 15'($urandom_range(1000));
         endcase
         set_flow(k);
         set_config(1'b1, 1'((k / 2) % 2), maxp, db);
         sent = 0;
         while (sent < RUN_ITEMS) begin
            n = $urandom_range(40, 10);
            queue_motion_run(n, longint'(maxp));
            sent += n;
            // sender holds off until the controller has answered everything
            if ($urandom_range(3) == 0)
               wait_drained();
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d ticks under %0d register settings, %0d result words checked",
               ticks_accepted, settings_count, results_checked);
      $display("reload requests %0d, stop edges %0d, mismatches %0d",
               reload_results, stop_results, mismatch_count);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // run limit
   initial begin : watchdog
      #(12_000_000);
      $display("TB_ERROR");
      $finish;
   end

endmodule

### filelist.f
src/mlpc_pkg.sv
src/mlpc_req_if.sv
src/mlpc_rsp_if.sv
src/mlpc_csr_if.sv
src/motorized_lift_position_controller.sv
src/mlpc_checker.sv
tb/motorized_lift_position_controller_tb.sv
